/* sv/dll_pkg.sv */
`default_nettype none

package dll_pkg;

    localparam int unsigned VAL_LIM_W = 13;
    localparam int unsigned ARG_LIM_W = 8;
    localparam int unsigned DIR_LIM_W = 13;
    localparam int unsigned SRC_LIM_W = 21;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 21;
    localparam int unsigned VLEN_W    = 14;
    localparam int unsigned DCNT_W    = 14;
    localparam int unsigned BCNT_W    = 22;

    localparam logic [VAL_LIM_W-1:0] VALUE_LIMIT_RST     = 13'd4096;
    localparam logic [ARG_LIM_W-1:0] ARGUMENT_LIMIT_RST  = 8'd128;
    localparam logic [DIR_LIM_W-1:0] DIRECTIVE_LIMIT_RST = 13'd4096;
    localparam logic [SRC_LIM_W-1:0] SOURCE_LIMIT_RST    = 21'd1048576;

    localparam logic [DCNT_W-1:0] DCNT_MAX = 14'd8192;

    localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARGUMENT_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTIVE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LIMIT    = 2'd3;

    typedef logic [1:0] event_kind_t;
    localparam event_kind_t EV_NONE  = 2'd0;
    localparam event_kind_t EV_DNAME = 2'd1;
    localparam event_kind_t EV_ANAME = 2'd2;
    localparam event_kind_t EV_VALUE = 2'd3;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_DOT    = 8'd46;
    localparam logic [7:0] CH_EQUAL  = 8'd61;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_UNDER  = 8'd95;
    localparam logic [7:0] CH_LOW_N  = 8'd110;
    localparam logic [7:0] CH_LOW_R  = 8'd114;
    localparam logic [7:0] CH_LOW_T  = 8'd116;

    typedef enum logic [14:0] {
        PH_LINE    = 15'h0001,
        PH_COMMENT = 15'h0002,
        PH_DNAME   = 15'h0004,
        PH_DWS     = 15'h0008,
        PH_ARG0    = 15'h0010,
        PH_ARGN    = 15'h0020,
        PH_ANAME   = 15'h0040,
        PH_AWS     = 15'h0080,
        PH_VWS     = 15'h0100,
        PH_TOKEN   = 15'h0200,
        PH_QUOTED  = 15'h0400,
        PH_ESC     = 15'h0800,
        PH_AFTER   = 15'h1000,
        PH_TAIL    = 15'h2000,
        PH_DEAD    = 15'h4000
    } phase_t;

    function automatic logic is_start(input logic [7:0] c);
        return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) || (c == CH_UNDER);
    endfunction

    function automatic logic is_part(input logic [7:0] c);
        return is_start(c) || (c >= 8'd48 && c <= 8'd57) || (c == CH_DOT) || (c == CH_MINUS);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

endpackage

`default_nettype wire

/* sv/directive_line_lexer.sv */
// channel  | direction | handshake            | payload
// in       | in        | in_valid / in_ready  | source_byte, end_of_source
// out      | out       | out_valid / out_ready| event_kind .. directive_total
// cfg      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per cycle while out_ready holds; an accepted item passes the input register, then the result register
// the lexer state update for an item is combinational between input and result registers
// a stalled result holds its register and the input register, in_ready drops
// reset restores the limit registers and returns the lexer to line start
// an end item reports status and returns the lexer to line start
`default_nettype none

module directive_line_lexer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      source_byte,
    input  wire logic                            end_of_source,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           event_kind,
    output logic [7:0]                           data_byte,
    output logic                                 value_quoted,
    output logic                                 value_end,
    output logic                                 directive_end,
    output logic                                 line_close,
    output logic                                 error_seen,
    output logic                                 done_res,
    output logic                                 final_status,
    output logic [13:0]                          directive_total,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dll_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dll_pkg::CFG_DAT_W-1:0]   cfg_data
);

    logic [dll_pkg::VAL_LIM_W-1:0] value_limit_reg;
    logic [dll_pkg::ARG_LIM_W-1:0] argument_limit_reg;
    logic [dll_pkg::DIR_LIM_W-1:0] directive_limit_reg;
    logic [dll_pkg::SRC_LIM_W-1:0] source_limit_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eos_reg;
    logic       s1_fire;

    dll_pkg::phase_t               phase_reg, phase_next;
    logic [dll_pkg::VLEN_W-1:0]    vlen_reg, vlen_next;
    logic [dll_pkg::ARG_LIM_W-1:0] acnt_reg, acnt_next;
    logic [dll_pkg::DCNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [dll_pkg::BCNT_W-1:0]    bcnt_reg, bcnt_next;
    logic                          quoted_reg, quoted_next;
    logic                          err_reg, err_next;

    logic                      out_valid_reg;
    dll_pkg::event_kind_t      kind_reg, kind_next;
    logic [7:0]                data_reg, data_next;
    logic                      vq_reg, vq_next;
    logic                      vend_reg, vend_next;
    logic                      dend_reg, dend_next;
    logic                      lend_reg, lend_next;
    logic                      errs_reg, errs_next;
    logic                      done_reg, done_next;
    logic                      stat_reg, stat_next;
    logic [dll_pkg::DCNT_W-1:0] total_reg, total_next;

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_limit_reg     <= dll_pkg::VALUE_LIMIT_RST;
            argument_limit_reg  <= dll_pkg::ARGUMENT_LIMIT_RST;
            directive_limit_reg <= dll_pkg::DIRECTIVE_LIMIT_RST;
            source_limit_reg    <= dll_pkg::SOURCE_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dll_pkg::REG_VALUE_LIMIT:
                    value_limit_reg <= cfg_data[dll_pkg::VAL_LIM_W-1:0];
                dll_pkg::REG_ARGUMENT_LIMIT:
                    argument_limit_reg <= cfg_data[dll_pkg::ARG_LIM_W-1:0];
                dll_pkg::REG_DIRECTIVE_LIMIT:
                    directive_limit_reg <= cfg_data[dll_pkg::DIR_LIM_W-1:0];
                dll_pkg::REG_SOURCE_LIMIT:
                    source_limit_reg <= cfg_data[dll_pkg::SRC_LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= source_byte;
            s1_eos_reg  <= end_of_source;
        end
    end

    always_comb
    begin
        logic [7:0]                 c;
        logic                       ok;
        logic                       at_line_rest;
        logic [dll_pkg::BCNT_W-1:0] bc_inc;
        logic [dll_pkg::DCNT_W-1:0] dc_inc;
        logic [dll_pkg::VLEN_W-1:0] vl_inc;
        dll_pkg::phase_t            eff;
        logic                       put;
        logic [7:0]                 pdata;
        logic                       close;
        logic                       begin_arg;
        logic                       tok;

        c            = s1_byte_reg;
        ok           = 1'b1;
        put          = 1'b0;
        pdata        = c;
        close        = 1'b0;
        begin_arg    = 1'b0;
        tok          = dll_pkg::is_part(c) || (c == dll_pkg::CH_PLUS);
        at_line_rest = (phase_reg == dll_pkg::PH_LINE) || (phase_reg == dll_pkg::PH_COMMENT)
                       || (phase_reg == dll_pkg::PH_TAIL);
        bc_inc = (bcnt_reg == {dll_pkg::BCNT_W{1'b1}}) ? bcnt_reg
                 : bcnt_reg + {{(dll_pkg::BCNT_W-1){1'b0}}, 1'b1};
        dc_inc = (dcnt_reg >= dll_pkg::DCNT_MAX) ? dcnt_reg
                 : dcnt_reg + {{(dll_pkg::DCNT_W-1){1'b0}}, 1'b1};

        phase_next  = phase_reg;
        vlen_next   = vlen_reg;
        acnt_next   = acnt_reg;
        dcnt_next   = dcnt_reg;
        bcnt_next   = bcnt_reg;
        quoted_next = quoted_reg;
        err_next    = err_reg;

        kind_next = dll_pkg::EV_NONE;
        data_next = s1_eos_reg ? 8'd0 : c;
        vq_next   = 1'b0;
        vend_next = 1'b0;
        dend_next = 1'b0;
        lend_next = s1_eos_reg || (c == dll_pkg::CH_NL);

        // name and token phases hand a non-member byte to the phase after them
        eff = phase_reg;
        if (phase_reg == dll_pkg::PH_DNAME && !dll_pkg::is_part(c))
        begin
            eff = dll_pkg::PH_DWS;
        end
        else if (phase_reg == dll_pkg::PH_ANAME && !dll_pkg::is_part(c))
        begin
            eff = dll_pkg::PH_AWS;
        end
        else if (phase_reg == dll_pkg::PH_TOKEN && !tok)
        begin
            eff       = dll_pkg::PH_AFTER;
            vend_next = 1'b1;
        end

        if (s1_eos_reg)
        begin
            if (!err_reg)
            begin
                ok         = at_line_rest;
                phase_next = dll_pkg::PH_LINE;
            end
        end
        else
        begin
            bcnt_next = bc_inc;
            if (!err_reg)
            begin
                if (bc_inc > {1'b0, source_limit_reg})
                begin
                    ok = 1'b0;
                end
                else if (c == dll_pkg::CH_NL)
                begin
                    ok         = at_line_rest;
                    phase_next = dll_pkg::PH_LINE;
                end
                else
                begin
                    phase_next = eff;
                    case (eff)
                        dll_pkg::PH_LINE:
                        begin
                            if (c == dll_pkg::CH_HASH)
                            begin
                                phase_next = dll_pkg::PH_COMMENT;
                            end
                            else if (dll_pkg::is_start(c))
                            begin
                                acnt_next  = '0;
                                kind_next  = dll_pkg::EV_DNAME;
                                phase_next = dll_pkg::PH_DNAME;
                            end
                            else if (!dll_pkg::is_ws(c))
                            begin
                                ok = 1'b0;
                            end
                        end
                        dll_pkg::PH_COMMENT:
                        begin
                        end
                        dll_pkg::PH_DNAME:
                        begin
                            kind_next = dll_pkg::EV_DNAME;
                        end
                        dll_pkg::PH_DWS:
                        begin
                            if (c == dll_pkg::CH_LPAREN)
                            begin
                                phase_next = dll_pkg::PH_ARG0;
                            end
                            else if (!dll_pkg::is_ws(c))
                            begin
                                ok = 1'b0;
                            end
                        end
                        dll_pkg::PH_ARG0:
                        begin
                            if (c == dll_pkg::CH_RPAREN)
                            begin
                                close = 1'b1;
                            end
                            else if (dll_pkg::is_start(c))
                            begin
                                begin_arg = 1'b1;
                            end
                            else if (!dll_pkg::is_ws(c))
                            begin
                                ok = 1'b0;
                            end
                        end
                        dll_pkg::PH_ARGN:
                        begin
                            if (dll_pkg::is_start(c))
                            begin
                                begin_arg = 1'b1;
                            end
                            else if (!dll_pkg::is_ws(c))
                            begin
                                ok = 1'b0;
                            end
                        end
                        dll_pkg::PH_ANAME:
                        begin
                            kind_next = dll_pkg::EV_ANAME;
                        end
                        dll_pkg::PH_AWS:
                        begin
                            if (c == dll_pkg::CH_EQUAL)
                            begin
                                phase_next = dll_pkg::PH_VWS;
                            end
                            else if (!dll_pkg::is_ws(c))
                            begin
                                ok = 1'b0;
                            end
                        end
                        dll_pkg::PH_VWS:
                        begin
                            if (!dll_pkg::is_ws(c))
                            begin
                                vlen_next = '0;
                                if (c == dll_pkg::CH_DQUOTE)
                                begin
                                    quoted_next = 1'b1;
                                    phase_next  = dll_pkg::PH_QUOTED;
                                end
                                else if (tok)
                                begin
                                    quoted_next = 1'b0;
                                    phase_next  = dll_pkg::PH_TOKEN;
                                    put         = 1'b1;
                                end
                                else
                                begin
                                    ok = 1'b0;
                                end
                            end
                        end
                        dll_pkg::PH_TOKEN:
                        begin
                            put = 1'b1;
                        end
                        dll_pkg::PH_QUOTED:
                        begin
                            if (c == dll_pkg::CH_DQUOTE)
                            begin
                                vend_next  = 1'b1;
                                vq_next    = 1'b1;
                                phase_next = dll_pkg::PH_AFTER;
                            end
                            else if (c == dll_pkg::CH_BSLASH)
                            begin
                                phase_next = dll_pkg::PH_ESC;
                            end
                            else
                            begin
                                put = 1'b1;
                            end
                        end
                        dll_pkg::PH_ESC:
                        begin
                            phase_next = dll_pkg::PH_QUOTED;
                            put        = 1'b1;
                            if (c == dll_pkg::CH_LOW_N)
                            begin
                                pdata = dll_pkg::CH_NL;
                            end
                            else if (c == dll_pkg::CH_LOW_R)
                            begin
                                pdata = dll_pkg::CH_CR;
                            end
                            else if (c == dll_pkg::CH_LOW_T)
                            begin
                                pdata = dll_pkg::CH_TAB;
                            end
                            else if (c != dll_pkg::CH_DQUOTE && c != dll_pkg::CH_BSLASH)
                            begin
                                put = 1'b0;
                                ok  = 1'b0;
                            end
                        end
                        dll_pkg::PH_AFTER:
                        begin
                            if (c == dll_pkg::CH_RPAREN)
                            begin
                                close = 1'b1;
                            end
                            else if (c == dll_pkg::CH_COMMA)
                            begin
                                phase_next = dll_pkg::PH_ARGN;
                            end
                            else if (!dll_pkg::is_ws(c))
                            begin
                                ok = 1'b0;
                            end
                        end
                        dll_pkg::PH_TAIL:
                        begin
                            if (c == dll_pkg::CH_HASH)
                            begin
                                phase_next = dll_pkg::PH_COMMENT;
                            end
                            else if (!dll_pkg::is_ws(c))
                            begin
                                ok = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end

        // value byte
        vl_inc = vlen_next + {{(dll_pkg::VLEN_W-1){1'b0}}, 1'b1};
        if (put)
        begin
            vlen_next = vl_inc;
            if (vl_inc > {1'b0, value_limit_reg})
            begin
                ok = 1'b0;
            end
            else
            begin
                kind_next = dll_pkg::EV_VALUE;
                data_next = pdata;
                vq_next   = quoted_next;
            end
        end

        // closing paren
        if (close)
        begin
            dcnt_next = dc_inc;
            if (dc_inc > {1'b0, directive_limit_reg})
            begin
                ok = 1'b0;
            end
            else
            begin
                dend_next  = 1'b1;
                phase_next = dll_pkg::PH_TAIL;
            end
        end

        // argument start
        if (begin_arg)
        begin
            if (acnt_reg >= argument_limit_reg)
            begin
                ok = 1'b0;
            end
            else
            begin
                acnt_next  = acnt_reg + {{(dll_pkg::ARG_LIM_W-1){1'b0}}, 1'b1};
                kind_next  = dll_pkg::EV_ANAME;
                phase_next = dll_pkg::PH_ANAME;
            end
        end

        if (!ok)
        begin
            err_next   = 1'b1;
            phase_next = dll_pkg::PH_DEAD;
        end
        if (err_next)
        begin
            kind_next = dll_pkg::EV_NONE;
            data_next = s1_eos_reg ? 8'd0 : c;
            vq_next   = 1'b0;
            vend_next = 1'b0;
            dend_next = 1'b0;
        end

        errs_next  = err_next;
        done_next  = s1_eos_reg;
        stat_next  = s1_eos_reg && err_next;
        total_next = dcnt_next;

        // end item starts a new source
        if (s1_eos_reg)
        begin
            phase_next  = dll_pkg::PH_LINE;
            vlen_next   = '0;
            acnt_next   = '0;
            dcnt_next   = '0;
            bcnt_next   = '0;
            quoted_next = 1'b0;
            err_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dll_pkg::PH_LINE;
            vlen_reg      <= '0;
            acnt_reg      <= '0;
            dcnt_reg      <= '0;
            bcnt_reg      <= '0;
            quoted_reg    <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                phase_reg  <= phase_next;
                vlen_reg   <= vlen_next;
                acnt_reg   <= acnt_next;
                dcnt_reg   <= dcnt_next;
                bcnt_reg   <= bcnt_next;
                quoted_reg <= quoted_next;
                err_reg    <= err_next;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            vq_reg    <= vq_next;
            vend_reg  <= vend_next;
            dend_reg  <= dend_next;
            lend_reg  <= lend_next;
            errs_reg  <= errs_next;
            done_reg  <= done_next;
            stat_reg  <= stat_next;
            total_reg <= total_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = kind_reg;
    assign data_byte       = data_reg;
    assign value_quoted    = vq_reg;
    assign value_end       = vend_reg;
    assign directive_end   = dend_reg;
    assign line_close      = lend_reg;
    assign error_seen      = errs_reg;
    assign done_res        = done_reg;
    assign final_status    = stat_reg;
    assign directive_total = total_reg;

endmodule

`default_nettype wire

/* sv/dll_checker.sv */
`default_nettype none

module dll_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [1:0]                    event_kind,
    input wire logic [7:0]                    data_byte,
    input wire logic                          value_quoted,
    input wire logic                          value_end,
    input wire logic                          directive_end,
    input wire logic                          line_close,
    input wire logic                          error_seen,
    input wire logic                          done_res,
    input wire logic                          final_status,
    input wire logic [13:0]                   directive_total
);

    // an end item always closes the line
    a_done_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> line_close)
        else $error("end item without line end");

    // status on an end item mirrors the sticky error
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> final_status == (done_res && error_seen))
        else $error("final status mismatch");

    // once in error, no classification is reported
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_seen |-> event_kind == dll_pkg::EV_NONE && !value_quoted
                                    && !value_end && !directive_end)
        else $error("classified item while in error");

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte)
                                    && $stable(directive_total))
        else $error("stalled item changed");

endmodule

bind directive_line_lexer dll_checker u_dll_checker (.*);

`default_nettype wire

/* sim/tb_directive_line_lexer.sv */
`timescale 1ns / 1ps

module tb_directive_line_lexer;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 200;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic [7:0] gap;
    } src_item_t;

    typedef struct packed {
        dll_pkg::event_kind_t kind;
        logic [7:0]  data;
        logic        vq;
        logic        vend;
        logic        dend;
        logic        lend;
        logic        err;
        logic        done;
        logic        status;
        logic [13:0] total;
    } lex_event_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [7:0]                    source_byte = 8'd0;
    logic                          end_of_source = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [1:0]                    event_kind;
    logic [7:0]                    data_byte;
    logic                          value_quoted;
    logic                          value_end;
    logic                          directive_end;
    logic                          line_close;
    logic                          error_seen;
    logic                          done_res;
    logic                          final_status;
    logic [13:0]                   directive_total;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [dll_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dll_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    directive_line_lexer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .source_byte     (source_byte),
        .end_of_source   (end_of_source),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .event_kind      (event_kind),
        .data_byte       (data_byte),
        .value_quoted    (value_quoted),
        .value_end       (value_end),
        .directive_end   (directive_end),
        .line_close      (line_close),
        .error_seen      (error_seen),
        .done_res        (done_res),
        .final_status    (final_status),
        .directive_total (directive_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // lexer copy kept by the testbench
    logic [dll_pkg::VAL_LIM_W-1:0] lim_value  = dll_pkg::VALUE_LIMIT_RST;
    logic [dll_pkg::ARG_LIM_W-1:0] lim_args   = dll_pkg::ARGUMENT_LIMIT_RST;
    logic [dll_pkg::DIR_LIM_W-1:0] lim_dirs   = dll_pkg::DIRECTIVE_LIMIT_RST;
    logic [dll_pkg::SRC_LIM_W-1:0] lim_source = dll_pkg::SOURCE_LIMIT_RST;
    dll_pkg::phase_t               lx_phase   = dll_pkg::PH_LINE;
    int                            lx_vlen    = 0;
    int                            lx_args    = 0;
    int                            lx_dirs    = 0;
    int                            lx_bytes   = 0;
    logic                          lx_quoted  = 1'b0;
    logic                          lx_err     = 1'b0;
    lex_event_t                    ev;

    src_item_t  pending_bytes[$];
    lex_event_t events_due[$];

    int   items_queued = 0;
    int   items_in = 0;
    int   results_seen = 0;
    int   sources_closed = 0;
    int   sources_rejected = 0;
    int   reg_writes = 0;
    int   mismatches = 0;
    int   noise_rate = 0;
    int   feed_calm = 0;
    int   feed_idle = 0;
    int   drain_calm = 0;
    int   drain_stall = 0;
    int   quiet_cycles = 0;
    logic hold_off = 1'b0;

    function automatic logic name_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == dll_pkg::CH_UNDER;
    endfunction

    function automatic logic name_tail(input logic [7:0] c);
        return name_head(c) || (c >= "0" && c <= "9") || c == dll_pkg::CH_DOT
               || c == dll_pkg::CH_MINUS;
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return c == dll_pkg::CH_SPACE || c == dll_pkg::CH_TAB || c == dll_pkg::CH_CR;
    endfunction

    function automatic logic take_value(input logic [7:0] d);
        lx_vlen++;
        if (lx_vlen > int'(lim_value))
            return 1'b0;
        ev.kind = dll_pkg::EV_VALUE;
        ev.data = d;
        ev.vq = lx_quoted;
        return 1'b1;
    endfunction

    function automatic logic close_directive();
        if (lx_dirs < 8192)
            lx_dirs++;
        if (lx_dirs > int'(lim_dirs))
            return 1'b0;
        ev.dend = 1'b1;
        lx_phase = dll_pkg::PH_TAIL;
        return 1'b1;
    endfunction

    function automatic logic open_argument();
        if (lx_args >= int'(lim_args))
            return 1'b0;
        lx_args++;
        ev.kind = dll_pkg::EV_ANAME;
        lx_phase = dll_pkg::PH_ANAME;
        return 1'b1;
    endfunction

    function automatic logic lex_char(input logic [7:0] c, input logic eol);
        logic again;
        logic ok;
        if (eol)
        begin
            if (lx_phase != dll_pkg::PH_LINE && lx_phase != dll_pkg::PH_COMMENT
                && lx_phase != dll_pkg::PH_TAIL)
                return 1'b0;
            lx_phase = dll_pkg::PH_LINE;
            return 1'b1;
        end
        ok = 1'b1;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (lx_phase)
                dll_pkg::PH_LINE:
                    if (blank_byte(c))
                        ;
                    else if (c == dll_pkg::CH_HASH)
                        lx_phase = dll_pkg::PH_COMMENT;
                    else if (name_head(c))
                    begin
                        lx_args = 0;
                        ev.kind = dll_pkg::EV_DNAME;
                        lx_phase = dll_pkg::PH_DNAME;
                    end
                    else
                        ok = 1'b0;
                dll_pkg::PH_COMMENT:
                    ;
                dll_pkg::PH_DNAME:
                    if (name_tail(c))
                        ev.kind = dll_pkg::EV_DNAME;
                    else
                    begin
                        lx_phase = dll_pkg::PH_DWS;
                        again = 1'b1;
                    end
                dll_pkg::PH_DWS:
                    if (blank_byte(c))
                        ;
                    else if (c == dll_pkg::CH_LPAREN)
                        lx_phase = dll_pkg::PH_ARG0;
                    else
                        ok = 1'b0;
                dll_pkg::PH_ARG0:
                    if (blank_byte(c))
                        ;
                    else if (c == dll_pkg::CH_RPAREN)
                        ok = close_directive();
                    else if (name_head(c))
                        ok = open_argument();
                    else
                        ok = 1'b0;
                dll_pkg::PH_ARGN:
                    if (blank_byte(c))
                        ;
                    else if (name_head(c))
                        ok = open_argument();
                    else
                        ok = 1'b0;
                dll_pkg::PH_ANAME:
                    if (name_tail(c))
                        ev.kind = dll_pkg::EV_ANAME;
                    else
                    begin
                        lx_phase = dll_pkg::PH_AWS;
                        again = 1'b1;
                    end
                dll_pkg::PH_AWS:
                    if (blank_byte(c))
                        ;
                    else if (c == dll_pkg::CH_EQUAL)
                        lx_phase = dll_pkg::PH_VWS;
                    else
                        ok = 1'b0;
                dll_pkg::PH_VWS:
                    if (!blank_byte(c))
                    begin
                        lx_vlen = 0;
                        if (c == dll_pkg::CH_DQUOTE)
                        begin
                            lx_quoted = 1'b1;
                            lx_phase = dll_pkg::PH_QUOTED;
                        end
                        else if (name_tail(c) || c == dll_pkg::CH_PLUS)
                        begin
                            lx_quoted = 1'b0;
                            lx_phase = dll_pkg::PH_TOKEN;
                            ok = take_value(c);
                        end
                        else
                            ok = 1'b0;
                    end
                dll_pkg::PH_TOKEN:
                    if (name_tail(c) || c == dll_pkg::CH_PLUS)
                        ok = take_value(c);
                    else
                    begin
                        ev.vend = 1'b1;
                        lx_phase = dll_pkg::PH_AFTER;
                        again = 1'b1;
                    end
                dll_pkg::PH_QUOTED:
                    if (c == dll_pkg::CH_DQUOTE)
                    begin
                        ev.vend = 1'b1;
                        ev.vq = 1'b1;
                        lx_phase = dll_pkg::PH_AFTER;
                    end
                    else if (c == dll_pkg::CH_BSLASH)
                        lx_phase = dll_pkg::PH_ESC;
                    else
                        ok = take_value(c);
                dll_pkg::PH_ESC:
                begin
                    lx_phase = dll_pkg::PH_QUOTED;
                    if (c == dll_pkg::CH_DQUOTE || c == dll_pkg::CH_BSLASH)
                        ok = take_value(c);
                    else if (c == dll_pkg::CH_LOW_N)
                        ok = take_value(dll_pkg::CH_NL);
                    else if (c == dll_pkg::CH_LOW_R)
                        ok = take_value(dll_pkg::CH_CR);
                    else if (c == dll_pkg::CH_LOW_T)
                        ok = take_value(dll_pkg::CH_TAB);
                    else
                        ok = 1'b0;
                end
                dll_pkg::PH_AFTER:
                    if (blank_byte(c))
                        ;
                    else if (c == dll_pkg::CH_RPAREN)
                        ok = close_directive();
                    else if (c == dll_pkg::CH_COMMA)
                        lx_phase = dll_pkg::PH_ARGN;
                    else
                        ok = 1'b0;
                dll_pkg::PH_TAIL:
                    if (blank_byte(c))
                        ;
                    else if (c == dll_pkg::CH_HASH)
                        lx_phase = dll_pkg::PH_COMMENT;
                    else
                        ok = 1'b0;
                default:
                    ;
            endcase
        end
        return ok;
    endfunction

    function automatic lex_event_t lex_next_byte(input logic [7:0] c, input logic eos);
        logic ok;
        ev = '0;
        ev.data = eos ? 8'd0 : c;
        ok = 1'b1;
        if (eos)
        begin
            ev.lend = 1'b1;
            if (!lx_err)
                ok = lex_char(8'd0, 1'b1);
        end
        else
        begin
            if (c == dll_pkg::CH_NL)
                ev.lend = 1'b1;
            if (lx_bytes < 32'h3FFFFF)
                lx_bytes++;
            if (!lx_err)
            begin
                if (lx_bytes > int'(lim_source))
                    ok = 1'b0;
                else
                    ok = lex_char(c, c == dll_pkg::CH_NL);
            end
        end
        if (!ok)
        begin
            lx_err = 1'b1;
            lx_phase = dll_pkg::PH_DEAD;
        end
        if (lx_err)
        begin
            ev.kind = dll_pkg::EV_NONE;
            ev.data = eos ? 8'd0 : c;
            ev.vq = 1'b0;
            ev.vend = 1'b0;
            ev.dend = 1'b0;
        end
        ev.err = lx_err;
        ev.total = lx_dirs[13:0];
        if (eos)
        begin
            ev.done = 1'b1;
            ev.status = lx_err;
            lx_phase = dll_pkg::PH_LINE;
            lx_vlen = 0;
            lx_args = 0;
            lx_dirs = 0;
            lx_bytes = 0;
            lx_quoted = 1'b0;
            lx_err = 1'b0;
        end
        return ev;
    endfunction

    function automatic int draw_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_src(input logic [7:0] b, input logic eos);
        src_item_t item;
        int        g;
        if (feed_calm > 0)
        begin
            feed_calm--;
            g = 0;
        end
        else
        begin
            if ($urandom_range(0, 59) == 0)
                feed_calm = $urandom_range(20, 100);
            g = draw_pause();
        end
        item.ch = b;
        item.eos = eos;
        item.gap = g[7:0];
        pending_bytes.insert(pending_bytes.size(), item);
        items_queued++;
    endtask

    // occasional dropped or replaced byte breaks the syntax
    task automatic put_char(input logic [7:0] b);
        int unsigned r;
        r = $urandom_range(0, 999);
        if (r < noise_rate)
        begin
            if (r[0])
                push_src(8'($urandom_range(0, 255)), 1'b0);
        end
        else
            push_src(b, 1'b0);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    function automatic logic [7:0] rand_head();
        int unsigned r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'd97 + r[7:0];
        if (r < 52)
            return 8'd65 + r[7:0] - 8'd26;
        return dll_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_tail();
        int unsigned r;
        int unsigned digit;
        r = $urandom_range(0, 15);
        digit = $urandom_range(0, 9);
        if (r < 10)
            return rand_head();
        if (r < 14)
            return 8'd48 + digit[7:0];
        if (r == 14)
            return dll_pkg::CH_DOT;
        return dll_pkg::CH_MINUS;
    endfunction

    task automatic put_blanks(input int most);
        int n;
        n = $urandom_range(0, most);
        repeat (n)
        begin
            case ($urandom_range(0, 2))
                0: put_char(dll_pkg::CH_SPACE);
                1: put_char(dll_pkg::CH_TAB);
                default: put_char(dll_pkg::CH_CR);
            endcase
        end
    endtask

    task automatic put_name();
        int n;
        n = $urandom_range(0, 4);
        put_char(rand_head());
        repeat (n)
            put_char(rand_tail());
    endtask

    task automatic put_value();
        int          n;
        int unsigned r;
        logic [7:0]  c;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
        if ($urandom_range(0, 99) < 55)
        begin
            repeat (n)
                put_char(($urandom_range(0, 7) == 0) ? dll_pkg::CH_PLUS : rand_tail());
        end
        else
        begin
            put_char(dll_pkg::CH_DQUOTE);
            repeat (n - 1)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    c = 8'($urandom_range(32, 126));
                    put_char((c == dll_pkg::CH_DQUOTE || c == dll_pkg::CH_BSLASH)
                             ? dll_pkg::CH_SPACE : c);
                end
                else if (r < 85)
                begin
                    put_char(dll_pkg::CH_BSLASH);
                    case ($urandom_range(0, 4))
                        0: put_char(dll_pkg::CH_DQUOTE);
                        1: put_char(dll_pkg::CH_BSLASH);
                        2: put_char(dll_pkg::CH_LOW_N);
                        3: put_char(dll_pkg::CH_LOW_R);
                        default: put_char(dll_pkg::CH_LOW_T);
                    endcase
                end
                else if (r < 88)
                begin
                    put_char(dll_pkg::CH_BSLASH);
                    put_char(8'($urandom_range(0, 255)));
                end
                else
                    put_char(8'($urandom_range(0, 255)));
            end
            put_char(dll_pkg::CH_DQUOTE);
        end
    endtask

    task automatic put_line(input logic with_nl);
        int unsigned r;
        int          n;
        r = $urandom_range(0, 99);
        if (r < 8)
            put_blanks(3);
        else if (r < 16)
        begin
            put_blanks(2);
            put_char(dll_pkg::CH_HASH);
            n = $urandom_range(0, 6);
            repeat (n)
                put_char(8'($urandom_range(11, 255)));
        end
        else if (r < 21)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                put_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            put_name();
            put_blanks(1);
            put_char(dll_pkg::CH_LPAREN);
            put_blanks(1);
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++)
            begin
                if (k > 0)
                begin
                    put_char(dll_pkg::CH_COMMA);
                    put_blanks(1);
                end
                put_name();
                put_blanks(1);
                put_char(dll_pkg::CH_EQUAL);
                put_blanks(1);
                put_value();
                put_blanks(1);
            end
            put_char(dll_pkg::CH_RPAREN);
            if ($urandom_range(0, 9) < 3)
            begin
                put_blanks(2);
                if ($urandom_range(0, 1) == 0)
                begin
                    put_char(dll_pkg::CH_HASH);
                    put_char(rand_tail());
                end
            end
        end
        if (with_nl)
            put_char(dll_pkg::CH_NL);
    endtask

    task automatic put_source();
        int lines;
        noise_rate = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(10, 40);
        lines = $urandom_range(1, 6);
        for (int i = 0; i < lines; i++)
            put_line(i < lines - 1 || $urandom_range(0, 3) != 0);
        push_src(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic fill_sources(input int more);
        int target;
        target = items_queued + more;
        while (items_queued < target)
            put_source();
    endtask

    task automatic settle();
        while (items_in != items_queued || events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [dll_pkg::CFG_IDX_W-1:0] idx,
                               input logic [dll_pkg::CFG_DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            dll_pkg::REG_VALUE_LIMIT:     lim_value = val[dll_pkg::VAL_LIM_W-1:0];
            dll_pkg::REG_ARGUMENT_LIMIT:  lim_args = val[dll_pkg::ARG_LIM_W-1:0];
            dll_pkg::REG_DIRECTIVE_LIMIT: lim_dirs = val[dll_pkg::DIR_LIM_W-1:0];
            default:                      lim_source = val[dll_pkg::SRC_LIM_W-1:0];
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [dll_pkg::CFG_DAT_W-1:0] v,
                              input logic [dll_pkg::CFG_DAT_W-1:0] a,
                              input logic [dll_pkg::CFG_DAT_W-1:0] d,
                              input logic [dll_pkg::CFG_DAT_W-1:0] s);
        write_limit(dll_pkg::REG_VALUE_LIMIT, v);
        write_limit(dll_pkg::REG_ARGUMENT_LIMIT, a);
        write_limit(dll_pkg::REG_DIRECTIVE_LIMIT, d);
        write_limit(dll_pkg::REG_SOURCE_LIMIT, s);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : feed_proc
        src_item_t nxt;
        logic      offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            feed_idle = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                events_due.insert(events_due.size(), lex_next_byte(source_byte, end_of_source));
                items_in++;
            end
            if (!in_valid || in_ready)
            begin
                offer = 1'b0;
                if (pending_bytes.size() > 0)
                begin
                    nxt = pending_bytes[0];
                    if (feed_idle >= int'(nxt.gap))
                    begin
                        void'(pending_bytes.pop_front());
                        source_byte <= nxt.ch;
                        end_of_source <= nxt.eos;
                        offer = 1'b1;
                        feed_idle = 0;
                    end
                    else
                        feed_idle++;
                end
                in_valid <= offer;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (drain_calm > 0)
                begin
                    drain_calm--;
                    drain_stall = 0;
                end
                else
                begin
                    if ($urandom_range(0, 59) == 0)
                        drain_calm = $urandom_range(20, 100);
                    drain_stall = draw_pause();
                end
            end
            if (hold_off)
                out_ready <= 1'b0;
            else if (drain_stall > 0)
            begin
                drain_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    initial
    begin
        wait (results_seen >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : check_proc
        lex_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (events_due.size() == 0)
            begin
                $error("result item with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = events_due.pop_front();
                check_field("event_kind", 32'(want.kind), 32'(event_kind));
                check_field("data_byte", 32'(want.data), 32'(data_byte));
                check_field("value_quoted", 32'(want.vq), 32'(value_quoted));
                check_field("value_end", 32'(want.vend), 32'(value_end));
                check_field("directive_end", 32'(want.dend), 32'(directive_end));
                check_field("line_close", 32'(want.lend), 32'(line_close));
                check_field("error_seen", 32'(want.err), 32'(error_seen));
                check_field("done_res", 32'(want.done), 32'(done_res));
                check_field("final_status", 32'(want.status), 32'(final_status));
                check_field("directive_total", 32'(want.total), 32'(directive_total));
                if (want.done)
                begin
                    sources_closed++;
                    if (want.status)
                        sources_rejected++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("directive_line_lexer test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // escapes, comments, leading blanks, error byte and bytes after an error
        noise_rate = 0;
        push_text("d(a=+_,b=\"\\\"\\\\\\n\\r\\t\")#\n");
        push_src(8'hA5, 1'b1);
        push_text("\t\015 x( )");
        push_src(8'h00, 1'b1);
        push_text("y(a=1\n)\n");
        push_src(8'hFF, 1'b1);
        push_text("z(a=\"\\q\")");
        push_src(8'h5A, 1'b1);
        push_src(8'hFF, 1'b0);
        push_src(8'h00, 1'b0);
        push_src(8'h7F, 1'b1);
        fill_sources(500);
        settle();

        set_limits(21'd1, 21'd1, 21'd1, 21'd48);
        fill_sources(200);
        settle();

        set_limits(21'd8191, 21'd255, 21'd8191, 21'd2097151);
        fill_sources(300);
        settle();

        // zero limits reject the first unit
        set_limits(21'd0, 21'd255, 21'd8191, 21'd2097151);
        fill_sources(60);
        settle();
        set_limits(21'd8191, 21'd0, 21'd0, 21'd2097151);
        fill_sources(60);
        settle();
        set_limits(21'd4096, 21'd128, 21'd4096, 21'd0);
        fill_sources(20);
        settle();

        repeat (3)
        begin
            set_limits(21'($urandom_range(1, 6)), 21'($urandom_range(1, 4)),
                       21'($urandom_range(1, 4)), 21'($urandom_range(30, 250)));
            fill_sources(120);
            settle();
        end

        $display("%0d items sent and %0d results checked under %0d register writes",
                 items_in, results_seen, reg_writes);
        $display("%0d sources closed, %0d rejected, %0d mismatches",
                 sources_closed, sources_rejected, mismatches);
        if (mismatches == 0 && events_due.size() == 0)
            $display("directive_line_lexer test passed");
        else
            $display("directive_line_lexer test failed");
        $finish;
    end

endmodule
